/* sv/iaeu_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iaeu_pkg
// Types, operation codes and helper functions shared by the integer execute
// unit: operand shifter, extender, add-with-carry and condition test.
// ----------------------------------------------------------------------------
package iaeu_pkg;

  typedef enum logic [5:0] {
    OP_ADDS_X_IMM   = 6'd0,
    OP_ADD_W_IMM    = 6'd1,
    OP_ADD_W_SHF    = 6'd2,
    OP_ADD_X_IMM    = 6'd3,
    OP_ADD_X_EXT    = 6'd4,
    OP_ADD_X_SHF    = 6'd5,
    OP_ADRP         = 6'd6,
    OP_ANDS_W_SHF   = 6'd7,
    OP_AND_W_IMM    = 6'd8,
    OP_AND_X_IMM    = 6'd9,
    OP_AND_X_SHF    = 6'd10,
    OP_B            = 6'd11,
    OP_B_COND       = 6'd12,
    OP_BL           = 6'd13,
    OP_BR           = 6'd14,
    OP_BLR          = 6'd15,
    OP_CBNZ_W       = 6'd16,
    OP_CBNZ_X       = 6'd17,
    OP_CBZ_W        = 6'd18,
    OP_CBZ_X        = 6'd19,
    OP_CCMP_X_IMM   = 6'd20,
    OP_CSEL_X       = 6'd21,
    OP_CSINC_W      = 6'd22,
    OP_CSINC_X      = 6'd23,
    OP_MADD_X       = 6'd24,
    OP_MOVK_W       = 6'd25,
    OP_MOVN_W       = 6'd26,
    OP_MOVN_X       = 6'd27,
    OP_MOVZ_W       = 6'd28,
    OP_MOVZ_X       = 6'd29,
    OP_ORR_W_IMM    = 6'd30,
    OP_ORR_W_SHF    = 6'd31,
    OP_ORR_X_IMM    = 6'd32,
    OP_ORR_X_SHF    = 6'd33,
    OP_RET          = 6'd34,
    OP_SUBS_W_IMM   = 6'd35,
    OP_SUBS_W_SHF   = 6'd36,
    OP_SUBS_X_IMM   = 6'd37,
    OP_SUBS_X_SHF   = 6'd38,
    OP_SUB_W_IMM    = 6'd39,
    OP_SUB_X_IMM    = 6'd40,
    OP_SUB_X_SHF    = 6'd41,
    OP_SVC          = 6'd42,
    OP_TBNZ         = 6'd43,
    OP_TBZ          = 6'd44,
    OP_UBFM_X       = 6'd45,
    OP_UDIV_X       = 6'd46
  } op_t;

  localparam logic [3:0] MOD_LSL  = 4'd1;
  localparam logic [3:0] MOD_LSR  = 4'd2;
  localparam logic [3:0] MOD_ASR  = 4'd3;
  localparam logic [3:0] MOD_ROR  = 4'd4;
  localparam logic [3:0] MOD_UXTB = 4'd5;
  localparam logic [3:0] MOD_UXTH = 4'd6;
  localparam logic [3:0] MOD_UXTW = 4'd7;
  localparam logic [3:0] MOD_SXTB = 4'd9;
  localparam logic [3:0] MOD_SXTH = 4'd10;
  localparam logic [3:0] MOD_SXTW = 4'd11;

  localparam logic [1:0] EXC_NONE  = 2'd0;
  localparam logic [1:0] EXC_UNIMP = 2'd1;
  localparam logic [1:0] EXC_SVC   = 2'd2;

  localparam logic [63:0] PAGE_MASK = 64'hFFF;
  localparam logic [63:0] HALF_MASK = 64'hFFFF;
  localparam logic [63:0] MASK32    = 64'hFFFF_FFFF;
  localparam logic [63:0] INSN_SIZE = 64'd4;

  // which unit supplies dest_value at the end of the pipe
  typedef enum logic [1:0] {
    SEL_ALU,
    SEL_MUL,
    SEL_DIV
  } res_sel_t;

  typedef struct packed {
    logic [5:0]  operation;
    logic [63:0] operand_a;
    logic [63:0] operand_b;
    logic [63:0] operand_c;
    logic [3:0]  flags_in;
    logic [3:0]  condition;
    logic [63:0] immediate;
    logic [5:0]  bit_field;
    logic [3:0]  fallback_flags;
    logic [3:0]  modifier_kind;
    logic [5:0]  shift_amount;
    logic [63:0] instruction_address;
  } insn_t;

  typedef struct packed {
    res_sel_t    sel;
    logic [63:0] dest_value;
    logic        dest_valid;
    logic [3:0]  flags_out;
    logic        flags_valid;
    logic        is_branch;
    logic        branch_taken;
    logic [63:0] branch_target;
    logic [1:0]  exception_code;
  } res_t;

  function automatic logic [63:0] shift_val(input logic [63:0] v, input logic [3:0] kind,
                                            input logic [5:0] amt, input logic is32);
    logic [31:0] w;
    logic [4:0]  a5;
    logic [63:0] r;
    w  = v[31:0];
    a5 = amt[4:0];
    if (is32) begin
      case (kind)
        MOD_LSL: r = {32'b0, w << a5};
        MOD_LSR: r = {32'b0, w >> a5};
        MOD_ASR: r = {32'b0, 32'($signed(w) >>> a5)};
        MOD_ROR: r = {32'b0, 32'({w, w} >> a5)};
        default: r = {32'b0, w};
      endcase
    end else begin
      case (kind)
        MOD_LSL: r = v << amt;
        MOD_LSR: r = v >> amt;
        MOD_ASR: r = 64'($signed(v) >>> amt);
        MOD_ROR: r = 64'({v, v} >> amt);
        default: r = v;
      endcase
    end
    return r;
  endfunction

  function automatic logic [63:0] extend_val(input logic [63:0] v, input logic [3:0] kind,
                                             input logic [5:0] amt);
    logic [63:0] e;
    case (kind)
      MOD_UXTB: e = {56'b0, v[7:0]};
      MOD_UXTH: e = {48'b0, v[15:0]};
      MOD_UXTW: e = {32'b0, v[31:0]};
      MOD_SXTB: e = {{56{v[7]}}, v[7:0]};
      MOD_SXTH: e = {{48{v[15]}}, v[15:0]};
      MOD_SXTW: e = {{32{v[31]}}, v[31:0]};
      default:  e = v;
    endcase
    return e << amt;
  endfunction

  // returns {N, Z, C, V, result}
  function automatic logic [67:0] add_carry(input logic [63:0] x, input logic [63:0] y,
                                            input logic cin, input logic is32);
    logic [64:0] s;
    logic [32:0] s32;
    logic [63:0] r;
    logic        n;
    logic        z;
    logic        c;
    logic        v;
    s   = {1'b0, x} + {1'b0, y} + 65'(cin);
    s32 = {1'b0, x[31:0]} + {1'b0, y[31:0]} + 33'(cin);
    if (is32) begin
      r = {32'b0, s32[31:0]};
      c = s32[32];
      v = ~(x[31] ^ y[31]) & (x[31] ^ r[31]);
      n = r[31];
    end else begin
      r = s[63:0];
      c = s[64];
      v = ~(x[63] ^ y[63]) & (x[63] ^ r[63]);
      n = r[63];
    end
    z = (r == 64'b0);
    return {n, z, c, v, r};
  endfunction

  function automatic logic cond_holds(input logic [3:0] cond, input logic [3:0] f);
    logic r;
    case (cond[3:1])
      3'd0:    r = f[2];
      3'd1:    r = f[1];
      3'd2:    r = f[3];
      3'd3:    r = f[0];
      3'd4:    r = f[1] & ~f[2];
      3'd5:    r = (f[3] == f[0]);
      3'd6:    r = (f[3] == f[0]) & ~f[2];
      default: r = 1'b1;
    endcase
    // AL and NV both always hold
    if (cond[3:1] == 3'd7) return 1'b1;
    return cond[0] ? ~r : r;
  endfunction

endpackage

/* sv/iaeu_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iaeu_if
// Valid/ready channels for decoded instructions and execute results.
// ----------------------------------------------------------------------------
interface iaeu_in_if;
  logic               valid;
  logic               ready;
  logic [5:0]         operation;
  logic [63:0]        operand_a;
  logic [63:0]        operand_b;
  logic [63:0]        operand_c;
  logic [3:0]         flags_in;
  logic [3:0]         condition;
  logic signed [63:0] immediate;
  logic [5:0]         bit_field;
  logic [3:0]         fallback_flags;
  logic [3:0]         modifier_kind;
  logic [5:0]         shift_amount;
  logic [63:0]        instruction_address;

  modport source (output valid, operation, operand_a, operand_b, operand_c, flags_in,
                  condition, immediate, bit_field, fallback_flags, modifier_kind,
                  shift_amount, instruction_address, input ready);
  modport sink (input valid, operation, operand_a, operand_b, operand_c, flags_in,
                condition, immediate, bit_field, fallback_flags, modifier_kind,
                shift_amount, instruction_address, output ready);
endinterface

interface iaeu_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] dest_value;
  logic        dest_valid;
  logic [3:0]  flags_out;
  logic        flags_valid;
  logic        is_branch;
  logic        branch_taken;
  logic [63:0] branch_target;
  logic [1:0]  exception_code;

  modport source (output valid, dest_value, dest_valid, flags_out, flags_valid, is_branch,
                  branch_taken, branch_target, exception_code, input ready);
  modport sink (input valid, dest_value, dest_valid, flags_out, flags_valid, is_branch,
                branch_taken, branch_target, exception_code, output ready);
endinterface

/* sv/iaeu_alu.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iaeu_alu
// One registered stage: shifter/extender, adder, logic ops, moves, bitfield,
// condition evaluation and branch resolution.
// ----------------------------------------------------------------------------
module iaeu_alu (
  input  logic           clk,
  input  logic           en,
  input  iaeu_pkg::insn_t insn,
  output iaeu_pkg::res_t  res
);
  import iaeu_pkg::*;

  res_t        res_next;
  logic [63:0] a;
  logic [63:0] b;
  logic [63:0] c;
  logic [63:0] imm;
  logic [63:0] pc;
  logic [63:0] nxt;
  logic [63:0] offs_tgt;
  logic [63:0] shw;
  logic [63:0] shx;
  logic [63:0] ext;
  logic [63:0] imm16;
  logic [4:0]  sh5;
  logic [63:0] ones_s;
  logic [63:0] field;
  logic [67:0] acr;
  logic        ch;
  logic        tst;

  always_comb begin
    a        = insn.operand_a;
    b        = insn.operand_b;
    c        = insn.operand_c;
    imm      = insn.immediate;
    pc       = insn.instruction_address;
    nxt      = pc + INSN_SIZE;
    offs_tgt = pc + imm;
    shw      = shift_val(b, insn.modifier_kind, insn.shift_amount, 1'b1);
    shx      = shift_val(b, insn.modifier_kind, insn.shift_amount, 1'b0);
    ext      = extend_val(b, insn.modifier_kind, insn.shift_amount);
    imm16    = imm & HALF_MASK;
    sh5      = insn.shift_amount[4:0];
    ones_s   = ~64'b0 >> (6'd63 - insn.bit_field);
    field    = a & ones_s;
    ch       = cond_holds(insn.condition, insn.flags_in);
    acr      = '0;
    tst      = 1'b0;

    res_next                = '0;
    res_next.sel            = SEL_ALU;
    res_next.branch_target  = nxt;
    res_next.exception_code = EXC_NONE;

    unique case (insn.operation)
      OP_ADDS_X_IMM: begin
        acr = add_carry(a, imm, 1'b0, 1'b0);
        res_next.dest_value  = acr[63:0];
        res_next.flags_out   = acr[67:64];
        res_next.dest_valid  = 1'b1;
        res_next.flags_valid = 1'b1;
      end
      OP_ADD_W_IMM: begin
        res_next.dest_value = (a + imm) & MASK32;
        res_next.dest_valid = 1'b1;
      end
      OP_ADD_W_SHF: begin
        res_next.dest_value = (a + shw) & MASK32;
        res_next.dest_valid = 1'b1;
      end
      OP_ADD_X_IMM: begin
        res_next.dest_value = a + imm;
        res_next.dest_valid = 1'b1;
      end
      OP_ADD_X_EXT: begin
        res_next.dest_value = a + ext;
        res_next.dest_valid = 1'b1;
      end
      OP_ADD_X_SHF: begin
        res_next.dest_value = a + shx;
        res_next.dest_valid = 1'b1;
      end
      OP_ADRP: begin
        res_next.dest_value = (pc & ~PAGE_MASK) + imm;
        res_next.dest_valid = 1'b1;
      end
      OP_ANDS_W_SHF: begin
        res_next.dest_value  = a & shw & MASK32;
        res_next.flags_out   = {res_next.dest_value[31], res_next.dest_value == 64'b0, 2'b00};
        res_next.dest_valid  = 1'b1;
        res_next.flags_valid = 1'b1;
      end
      OP_AND_W_IMM: begin
        res_next.dest_value = a & imm & MASK32;
        res_next.dest_valid = 1'b1;
      end
      OP_AND_X_IMM: begin
        res_next.dest_value = a & imm;
        res_next.dest_valid = 1'b1;
      end
      OP_AND_X_SHF: begin
        res_next.dest_value = a & shx;
        res_next.dest_valid = 1'b1;
      end
      OP_B: begin
        res_next.is_branch     = 1'b1;
        res_next.branch_taken  = 1'b1;
        res_next.branch_target = offs_tgt;
      end
      OP_B_COND: begin
        res_next.is_branch     = 1'b1;
        res_next.branch_taken  = ch;
        res_next.branch_target = ch ? offs_tgt : nxt;
      end
      OP_BL: begin
        res_next.is_branch     = 1'b1;
        res_next.branch_taken  = 1'b1;
        res_next.branch_target = offs_tgt;
        res_next.dest_value    = nxt;
        res_next.dest_valid    = 1'b1;
      end
      OP_BR, OP_RET: begin
        res_next.is_branch     = 1'b1;
        res_next.branch_taken  = 1'b1;
        res_next.branch_target = a;
      end
      OP_BLR: begin
        res_next.is_branch     = 1'b1;
        res_next.branch_taken  = 1'b1;
        res_next.branch_target = a;
        res_next.dest_value    = nxt;
        res_next.dest_valid    = 1'b1;
      end
      OP_CBNZ_W, OP_CBNZ_X, OP_CBZ_W, OP_CBZ_X: begin
        if (insn.operation == OP_CBNZ_W || insn.operation == OP_CBZ_W) begin
          tst = (a[31:0] == 32'b0);
        end else begin
          tst = (a == 64'b0);
        end
        if (insn.operation == OP_CBNZ_W || insn.operation == OP_CBNZ_X) tst = ~tst;
        res_next.is_branch     = 1'b1;
        res_next.branch_taken  = tst;
        res_next.branch_target = tst ? offs_tgt : nxt;
      end
      OP_CCMP_X_IMM: begin
        acr = add_carry(a, ~imm, 1'b1, 1'b0);
        res_next.flags_out   = ch ? acr[67:64] : insn.fallback_flags;
        res_next.flags_valid = 1'b1;
      end
      OP_CSEL_X: begin
        res_next.dest_value = ch ? a : c;
        res_next.dest_valid = 1'b1;
      end
      OP_CSINC_W: begin
        res_next.dest_value = ch ? (a & MASK32) : ((c + 64'd1) & MASK32);
        res_next.dest_valid = 1'b1;
      end
      OP_CSINC_X: begin
        res_next.dest_value = ch ? a : c + 64'd1;
        res_next.dest_valid = 1'b1;
      end
      OP_MADD_X: begin
        res_next.sel        = SEL_MUL;
        res_next.dest_valid = 1'b1;
      end
      OP_MOVK_W: begin
        res_next.dest_value = ((a & ~(HALF_MASK << sh5)) | (imm16 << sh5)) & MASK32;
        res_next.dest_valid = 1'b1;
      end
      OP_MOVN_W: begin
        res_next.dest_value = ~(imm16 << sh5) & MASK32;
        res_next.dest_valid = 1'b1;
      end
      OP_MOVN_X: begin
        res_next.dest_value = ~(imm16 << insn.shift_amount);
        res_next.dest_valid = 1'b1;
      end
      OP_MOVZ_W: begin
        res_next.dest_value = (imm16 << sh5) & MASK32;
        res_next.dest_valid = 1'b1;
      end
      OP_MOVZ_X: begin
        res_next.dest_value = imm16 << insn.shift_amount;
        res_next.dest_valid = 1'b1;
      end
      OP_ORR_W_IMM: begin
        res_next.dest_value = (a | imm) & MASK32;
        res_next.dest_valid = 1'b1;
      end
      OP_ORR_W_SHF: begin
        res_next.dest_value = (a | shw) & MASK32;
        res_next.dest_valid = 1'b1;
      end
      OP_ORR_X_IMM: begin
        res_next.dest_value = a | imm;
        res_next.dest_valid = 1'b1;
      end
      OP_ORR_X_SHF: begin
        res_next.dest_value = a | shx;
        res_next.dest_valid = 1'b1;
      end
      OP_SUBS_W_IMM, OP_SUBS_W_SHF, OP_SUBS_X_IMM, OP_SUBS_X_SHF: begin
        unique case (insn.operation)
          OP_SUBS_W_IMM: acr = add_carry(a, ~imm, 1'b1, 1'b1);
          OP_SUBS_W_SHF: acr = add_carry(a, ~shw, 1'b1, 1'b1);
          OP_SUBS_X_IMM: acr = add_carry(a, ~imm, 1'b1, 1'b0);
          default:       acr = add_carry(a, ~shx, 1'b1, 1'b0);
        endcase
        res_next.dest_value  = acr[63:0];
        res_next.flags_out   = acr[67:64];
        res_next.dest_valid  = 1'b1;
        res_next.flags_valid = 1'b1;
      end
      OP_SUB_W_IMM: begin
        res_next.dest_value = (a - imm) & MASK32;
        res_next.dest_valid = 1'b1;
      end
      OP_SUB_X_IMM: begin
        res_next.dest_value = a - imm;
        res_next.dest_valid = 1'b1;
      end
      OP_SUB_X_SHF: begin
        res_next.dest_value = a - shx;
        res_next.dest_valid = 1'b1;
      end
      OP_SVC: begin
        res_next.exception_code = EXC_SVC;
      end
      OP_TBNZ, OP_TBZ: begin
        tst = a[insn.bit_field];
        if (insn.operation == OP_TBZ) tst = ~tst;
        res_next.is_branch     = 1'b1;
        res_next.branch_taken  = tst;
        res_next.branch_target = tst ? offs_tgt : nxt;
      end
      OP_UBFM_X: begin
        // s below r places the field at the top: rotate left by 64 - r
        if (insn.bit_field >= insn.shift_amount) begin
          res_next.dest_value = field >> insn.shift_amount;
        end else begin
          res_next.dest_value = field << (7'd64 - {1'b0, insn.shift_amount});
        end
        res_next.dest_valid = 1'b1;
      end
      OP_UDIV_X: begin
        res_next.sel        = SEL_DIV;
        res_next.dest_valid = 1'b1;
      end
      default: begin
        res_next.exception_code = EXC_UNIMP;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) res <= res_next;
  end

endmodule

/* sv/iaeu_mul.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iaeu_mul
// Two-stage multiply-add, low 64 bits of c + a * b, from three 32x32
// partial products.
// ----------------------------------------------------------------------------
module iaeu_mul (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] a,
  input  logic [63:0] b,
  input  logic [63:0] c,
  output logic [63:0] sum
);
  logic [63:0] pp_ll;
  logic [31:0] pp_lh;
  logic [31:0] pp_hl;
  logic [63:0] addend;

  always_ff @(posedge clk) begin
    if (en) begin
      pp_ll  <= {32'b0, a[31:0]} * {32'b0, b[31:0]};
      pp_lh  <= 32'(a[31:0] * b[63:32]);
      pp_hl  <= 32'(a[63:32] * b[31:0]);
      addend <= c;
      sum    <= addend + pp_ll + {pp_lh + pp_hl, 32'b0};
    end
  end

endmodule

/* sv/iaeu_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iaeu_div
// Unsigned 64-bit divider, one restoring step per stage, 64 stages.
// A zero divisor yields a zero quotient.
// ----------------------------------------------------------------------------
module iaeu_div (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] dividend,
  input  logic [63:0] divisor,
  output logic [63:0] quotient
);
  localparam int Steps = 64;

  logic [63:0] rem [0:Steps-1];
  logic [63:0] quo [0:Steps-1];
  logic [63:0] dvs [0:Steps-1];
  logic        dz  [0:Steps-1];

  for (genvar k = 0; k < Steps; k++) begin : g_step
    logic [63:0] rem_in;
    logic [63:0] quo_in;
    logic [63:0] dvs_in;
    logic        dz_in;
    logic [64:0] trial;
    logic [64:0] diff;

    if (k == 0) begin : g_first
      assign rem_in = '0;
      assign quo_in = dividend;
      assign dvs_in = divisor;
      assign dz_in  = (divisor == 64'b0);
    end else begin : g_rest
      assign rem_in = rem[k-1];
      assign quo_in = quo[k-1];
      assign dvs_in = dvs[k-1];
      assign dz_in  = dz[k-1];
    end

    // bring down the next dividend bit, subtract if it fits
    assign trial = {rem_in, quo_in[63]};
    assign diff  = trial - {1'b0, dvs_in};

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k] <= diff[64] ? trial[63:0] : diff[63:0];
        quo[k] <= {quo_in[62:0], ~diff[64]};
        dvs[k] <= dvs_in;
        dz[k]  <= dz_in;
      end
    end
  end

  assign quotient = dz[Steps-1] ? 64'b0 : quo[Steps-1];

endmodule

/* sv/aarch64_integer_execute_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aarch64_integer_execute_unit
// Integer execute unit for a 64-bit ARM subset: ALU, branch resolution,
// pipelined multiply-add and pipelined unsigned divide.
// ----------------------------------------------------------------------------
// Takes one instruction per cycle while the pipe advances and returns one result
// per instruction, in order, through the input register, the 64 divider steps and
// the output register. The depth is set by the divider, one quotient bit per
// stage; ALU and multiplier results ride a delay line alongside it. The whole
// pipe advances together: when the result register holds an untaken result,
// every stage holds and the input is not ready.
module aarch64_integer_execute_unit (
  input logic        clk,
  input logic        rst,
  iaeu_in_if.sink    req,
  iaeu_out_if.source rsp
);
  import iaeu_pkg::*;

  localparam int Depth   = 64;
  localparam int MulLat  = 2;

  logic        adv;
  insn_t       p0;
  logic        v0;
  res_t        alu_res;
  res_t        aline [0:Depth-2];
  logic        vline [0:Depth-1];
  logic [63:0] mul_sum;
  logic [63:0] mline [0:Depth-MulLat-1];
  logic [63:0] div_q;
  res_t        tail;
  res_t        out_r;
  res_t        out_next;
  logic        out_valid;

  assign adv       = ~out_valid | rsp.ready;
  assign req.ready = adv;

  always_ff @(posedge clk) begin
    if (adv) begin
      p0.operation           <= req.operation;
      p0.operand_a           <= req.operand_a;
      p0.operand_b           <= req.operand_b;
      p0.operand_c           <= req.operand_c;
      p0.flags_in            <= req.flags_in;
      p0.condition           <= req.condition;
      p0.immediate           <= req.immediate;
      p0.bit_field           <= req.bit_field;
      p0.fallback_flags      <= req.fallback_flags;
      p0.modifier_kind       <= req.modifier_kind;
      p0.shift_amount        <= req.shift_amount;
      p0.instruction_address <= req.instruction_address;
    end
  end

  iaeu_alu u_alu (
    .clk  (clk),
    .en   (adv),
    .insn (p0),
    .res  (alu_res)
  );

  iaeu_mul u_mul (
    .clk (clk),
    .en  (adv),
    .a   (p0.operand_a),
    .b   (p0.operand_b),
    .c   (p0.operand_c),
    .sum (mul_sum)
  );

  iaeu_div u_div (
    .clk      (clk),
    .en       (adv),
    .dividend (p0.operand_a),
    .divisor  (p0.operand_b),
    .quotient (div_q)
  );

  // delay lines that keep ALU and multiplier results level with the divider
  always_ff @(posedge clk) begin
    if (adv) begin
      aline[0] <= alu_res;
      for (int i = 1; i < Depth - 1; i++) aline[i] <= aline[i-1];
      mline[0] <= mul_sum;
      for (int i = 1; i < Depth - MulLat; i++) mline[i] <= mline[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0        <= 1'b0;
      out_valid <= 1'b0;
      for (int i = 0; i < Depth; i++) vline[i] <= 1'b0;
    end else if (adv) begin
      v0       <= req.valid;
      vline[0] <= v0;
      for (int i = 1; i < Depth; i++) vline[i] <= vline[i-1];
      out_valid <= vline[Depth-1];
    end
  end

  assign tail = aline[Depth-2];

  always_comb begin
    out_next = tail;
    case (tail.sel)
      SEL_MUL: out_next.dest_value = mline[Depth-MulLat-1];
      SEL_DIV: out_next.dest_value = div_q;
      default: out_next.dest_value = tail.dest_value;
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) out_r <= out_next;
  end

  assign rsp.valid          = out_valid;
  assign rsp.dest_value     = out_r.dest_value;
  assign rsp.dest_valid     = out_r.dest_valid;
  assign rsp.flags_out      = out_r.flags_out;
  assign rsp.flags_valid    = out_r.flags_valid;
  assign rsp.is_branch      = out_r.is_branch;
  assign rsp.branch_taken   = out_r.branch_taken;
  assign rsp.branch_target  = out_r.branch_target;
  assign rsp.exception_code = out_r.exception_code;

endmodule

/* sv/iaeu_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iaeu_checker
// Port-level checks on the execute unit's result channel.
// ----------------------------------------------------------------------------
module iaeu_checker (
  input logic        clk,
  input logic        rst,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [63:0] dest_value,
  input logic        dest_valid,
  input logic [3:0]  flags_out,
  input logic        flags_valid,
  input logic        is_branch,
  input logic        branch_taken,
  input logic [1:0]  exception_code
);
  import iaeu_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("result dropped while stalled");

  a_no_dest: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !dest_valid |-> dest_value == 64'b0)
    else $error("dest_value set without a destination write");

  a_no_flags: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !flags_valid |-> flags_out == 4'b0)
    else $error("flags_out set without a flag update");

  a_taken: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (!is_branch || exception_code != EXC_NONE) |-> !branch_taken)
    else $error("taken flag on a non-branch");

  a_exc: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && exception_code != EXC_NONE |-> !dest_valid && !flags_valid)
    else $error("exception with architectural update");

endmodule

bind aarch64_integer_execute_unit iaeu_checker u_iaeu_checker (
  .clk            (clk),
  .rst            (rst),
  .rsp_valid      (rsp.valid),
  .rsp_ready      (rsp.ready),
  .dest_value     (rsp.dest_value),
  .dest_valid     (rsp.dest_valid),
  .flags_out      (rsp.flags_out),
  .flags_valid    (rsp.flags_valid),
  .is_branch      (rsp.is_branch),
  .branch_taken   (rsp.branch_taken),
  .exception_code (rsp.exception_code)
);

/* dv/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench for the integer execute unit. Directed instructions cover every
// operation code, the operand extremes and the documented corner cases. Random
// instructions with random gaps and random result stalls follow. An in-order
// scoreboard predicts each result and compares every field.
// ----------------------------------------------------------------------------
module tb;
  import iaeu_pkg::*;

  localparam int HALF_PERIOD = 5;
  localparam int RESET_CYCLES = 8;
  localparam int NUM_RANDOM = 390;
  localparam int PIPE_DEPTH = 66;
  localparam int STALL_LIMIT = 4000;

  typedef struct packed {
    logic [63:0] dest_value;
    logic        dest_valid;
    logic [3:0]  flags_out;
    logic        flags_valid;
    logic        is_branch;
    logic        branch_taken;
    logic [63:0] branch_target;
    logic [1:0]  exception_code;
  } outcome_t;

  // ---- predictor ----
  class exec_scoreboard;
    outcome_t pending[$];
    int errors;
    int checked;

    function logic [63:0] mask_bits(input int n);
      return (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
    endfunction

    function logic [63:0] shifted(input logic [63:0] v, input logic [3:0] kind,
                                  input logic [5:0] amt, input bit w32);
      int width;
      int sa;
      logic [63:0] m;
      logic [63:0] r;
      width = w32 ? 32 : 64;
      m = mask_bits(width);
      v = v & m;
      sa = w32 ? int'(amt[4:0]) : int'(amt);
      r = v;
      if (kind == MOD_LSL) r = (v << sa) & m;
      else if (kind == MOD_LSR) r = v >> sa;
      else if (kind == MOD_ASR) begin
        r = v >> sa;
        if (v[width-1]) r = r | (m & ~(m >> sa));
      end else if (kind == MOD_ROR && sa != 0) r = ((v >> sa) | (v << (width - sa))) & m;
      return r;
    endfunction

    function logic [63:0] extended(input logic [63:0] v, input logic [3:0] kind,
                                   input logic [5:0] amt);
      logic [63:0] e;
      case (kind)
        MOD_UXTB: e = 64'(v[7:0]);
        MOD_UXTH: e = 64'(v[15:0]);
        MOD_UXTW: e = 64'(v[31:0]);
        MOD_SXTB: e = 64'(signed'(v[7:0]));
        MOD_SXTH: e = 64'(signed'(v[15:0]));
        MOD_SXTW: e = 64'(signed'(v[31:0]));
        default:  e = v;
      endcase
      return e << amt;
    endfunction

    // {nzcv, sum}
    function logic [67:0] sum_flags(input logic [63:0] x, input logic [63:0] y,
                                    input bit cin, input bit w32);
      logic [64:0] s;
      logic [63:0] r;
      bit n, z, c, v;
      if (w32) begin
        s = 65'(x[31:0]) + 65'(y[31:0]) + 65'(cin);
        r = 64'(s[31:0]);
        c = s[32];
        v = (x[31] == y[31]) && (x[31] != r[31]);
        n = r[31];
      end else begin
        s = 65'(x) + 65'(y) + 65'(cin);
        r = s[63:0];
        c = s[64];
        v = (x[63] == y[63]) && (x[63] != r[63]);
        n = r[63];
      end
      z = (r == 0);
      return {n, z, c, v, r};
    endfunction

    function bit passes(input logic [3:0] cnd, input logic [3:0] f);
      bit r;
      case (cnd[3:1])
        3'd0: r = f[2];
        3'd1: r = f[1];
        3'd2: r = f[3];
        3'd3: r = f[0];
        3'd4: r = f[1] && !f[2];
        3'd5: r = f[3] == f[0];
        3'd6: r = (f[3] == f[0]) && !f[2];
        default: return 1'b1;
      endcase
      return cnd[0] ? !r : r;
    endfunction

    function void note_insn(input insn_t i);
      outcome_t o;
      logic [67:0] af;
      logic [63:0] a, b, c, imm, pc, nxt, h16;
      bit t, wr, fv;
      logic [3:0] fl;
      logic [63:0] dv;
      a = i.operand_a; b = i.operand_b; c = i.operand_c;
      imm = i.immediate; pc = i.instruction_address; nxt = pc + INSN_SIZE;
      h16 = imm & HALF_MASK;
      o = '0;
      o.branch_target = nxt;
      wr = 1; fv = 0; fl = 0; dv = 0;
      case (i.operation)
        OP_ADDS_X_IMM: begin af = sum_flags(a, imm, 0, 0); dv = af[63:0]; fl = af[67:64];
          fv = 1; end
        OP_ADD_W_IMM: dv = (a + imm) & MASK32;
        OP_ADD_W_SHF: dv = (a + shifted(b, i.modifier_kind, i.shift_amount, 1)) & MASK32;
        OP_ADD_X_IMM: dv = a + imm;
        OP_ADD_X_EXT: dv = a + extended(b, i.modifier_kind, i.shift_amount);
        OP_ADD_X_SHF: dv = a + shifted(b, i.modifier_kind, i.shift_amount, 0);
        OP_ADRP: dv = (pc & ~PAGE_MASK) + imm;
        OP_ANDS_W_SHF: begin
          dv = a & shifted(b, i.modifier_kind, i.shift_amount, 1) & MASK32;
          fl = {dv[31], dv == 0, 2'b00}; fv = 1;
        end
        OP_AND_W_IMM: dv = a & imm & MASK32;
        OP_AND_X_IMM: dv = a & imm;
        OP_AND_X_SHF: dv = a & shifted(b, i.modifier_kind, i.shift_amount, 0);
        OP_B: begin wr = 0; o.is_branch = 1; o.branch_taken = 1; o.branch_target = pc + imm; end
        OP_B_COND: begin
          wr = 0; o.is_branch = 1; o.branch_taken = passes(i.condition, i.flags_in);
          if (o.branch_taken) o.branch_target = pc + imm;
        end
        OP_BL: begin o.is_branch = 1; o.branch_taken = 1; o.branch_target = pc + imm;
          dv = nxt; end
        OP_BR, OP_RET: begin wr = 0; o.is_branch = 1; o.branch_taken = 1;
          o.branch_target = a; end
        OP_BLR: begin o.is_branch = 1; o.branch_taken = 1; o.branch_target = a; dv = nxt; end
        OP_CBNZ_W, OP_CBNZ_X, OP_CBZ_W, OP_CBZ_X: begin
          wr = 0;
          t = (((i.operation == OP_CBNZ_W) || (i.operation == OP_CBZ_W)) ? (a & MASK32) : a)
              == 0;
          o.is_branch = 1;
          o.branch_taken = ((i.operation == OP_CBZ_W) || (i.operation == OP_CBZ_X)) ? t : !t;
          if (o.branch_taken) o.branch_target = pc + imm;
        end
        OP_CCMP_X_IMM: begin
          wr = 0; fv = 1;
          if (passes(i.condition, i.flags_in)) begin
            af = sum_flags(a, ~imm, 1, 0); fl = af[67:64];
          end else fl = i.fallback_flags;
        end
        OP_CSEL_X: dv = passes(i.condition, i.flags_in) ? a : c;
        OP_CSINC_W: dv = passes(i.condition, i.flags_in) ? (a & MASK32) : ((c + 1) & MASK32);
        OP_CSINC_X: dv = passes(i.condition, i.flags_in) ? a : c + 1;
        OP_MADD_X: dv = c + a * b;
        OP_MOVK_W: dv = ((a & ~(HALF_MASK << i.shift_amount[4:0])) |
                         (h16 << i.shift_amount[4:0])) & MASK32;
        OP_MOVN_W: dv = ~(h16 << i.shift_amount[4:0]) & MASK32;
        OP_MOVN_X: dv = ~(h16 << i.shift_amount);
        OP_MOVZ_W: dv = (h16 << i.shift_amount[4:0]) & MASK32;
        OP_MOVZ_X: dv = h16 << i.shift_amount;
        OP_ORR_W_IMM: dv = (a | imm) & MASK32;
        OP_ORR_W_SHF: dv = (a | shifted(b, i.modifier_kind, i.shift_amount, 1)) & MASK32;
        OP_ORR_X_IMM: dv = a | imm;
        OP_ORR_X_SHF: dv = a | shifted(b, i.modifier_kind, i.shift_amount, 0);
        OP_SUBS_W_IMM, OP_SUBS_W_SHF, OP_SUBS_X_IMM, OP_SUBS_X_SHF: begin
          t = (i.operation == OP_SUBS_W_IMM) || (i.operation == OP_SUBS_W_SHF);
          if ((i.operation == OP_SUBS_W_IMM) || (i.operation == OP_SUBS_X_IMM))
            af = sum_flags(a, ~imm, 1, t);
          else af = sum_flags(a, ~shifted(b, i.modifier_kind, i.shift_amount, t), 1, t);
          dv = af[63:0]; fl = af[67:64]; fv = 1;
        end
        OP_SUB_W_IMM: dv = (a - imm) & MASK32;
        OP_SUB_X_IMM: dv = a - imm;
        OP_SUB_X_SHF: dv = a - shifted(b, i.modifier_kind, i.shift_amount, 0);
        OP_SVC: begin wr = 0; o.exception_code = EXC_SVC; end
        OP_TBNZ, OP_TBZ: begin
          wr = 0; t = a[i.bit_field]; o.is_branch = 1;
          o.branch_taken = (i.operation == OP_TBNZ) ? t : !t;
          if (o.branch_taken) o.branch_target = pc + imm;
        end
        OP_UBFM_X: begin
          if (i.bit_field >= i.shift_amount)
            dv = (a & mask_bits(int'(i.bit_field) + 1)) >> i.shift_amount;
          else dv = (a & mask_bits(int'(i.bit_field) + 1)) << (64 - int'(i.shift_amount));
        end
        OP_UDIV_X: dv = (b == 0) ? 64'd0 : a / b;
        default: begin wr = 0; o.exception_code = EXC_UNIMP; end
      endcase
      o.dest_valid = wr;
      o.dest_value = wr ? dv : 64'd0;
      o.flags_valid = fv;
      o.flags_out = fv ? fl : 4'd0;
      pending.push_back(o);
    endfunction

    function void check_result(input outcome_t got);
      outcome_t w;
      if (pending.size() == 0) begin
        $error("result with no instruction outstanding");
        errors++;
        return;
      end
      w = pending.pop_front();
      checked++;
      if (got.dest_value !== w.dest_value) begin
        $error("dest_value exp %h got %h", w.dest_value, got.dest_value); errors++; end
      if (got.dest_valid !== w.dest_valid) begin
        $error("dest_valid exp %b got %b", w.dest_valid, got.dest_valid); errors++; end
      if (got.flags_out !== w.flags_out) begin
        $error("flags_out exp %h got %h", w.flags_out, got.flags_out); errors++; end
      if (got.flags_valid !== w.flags_valid) begin
        $error("flags_valid exp %b got %b", w.flags_valid, got.flags_valid); errors++; end
      if (got.is_branch !== w.is_branch) begin
        $error("is_branch exp %b got %b", w.is_branch, got.is_branch); errors++; end
      if (got.branch_taken !== w.branch_taken) begin
        $error("branch_taken exp %b got %b", w.branch_taken, got.branch_taken); errors++; end
      if (got.branch_target !== w.branch_target) begin
        $error("branch_target exp %h got %h", w.branch_target, got.branch_target); errors++; end
      if (got.exception_code !== w.exception_code) begin
        $error("exception_code exp %0d got %0d", w.exception_code, got.exception_code);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  iaeu_in_if req ();
  iaeu_out_if rsp ();

  aarch64_integer_execute_unit u_dut (
    .clk(clk),
    .rst(rst),
    .req(req.sink),
    .rsp(rsp.source)
  );

  exec_scoreboard sb = new();
  int idle_cycles;
  bit stim_done;

  always #HALF_PERIOD clk = ~clk;

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // corner-heavy operand values
  function automatic logic [63:0] pick64();
    case ($urandom_range(0, 7))
      0: return 64'd0;
      1: return '1;
      2: return 64'h8000_0000_0000_0000;
      3: return 64'h7FFF_FFFF_FFFF_FFFF;
      4: return 64'(32'($urandom()));
      5: return 64'($urandom_range(0, 15));
      default: return rand64();
    endcase
  endfunction

  function automatic insn_t random_insn();
    insn_t i;
    i.operation = ($urandom_range(0, 15) == 0) ? 6'($urandom_range(47, 63))
                                               : 6'($urandom_range(0, 46));
    i.operand_a = pick64();
    i.operand_b = pick64();
    i.operand_c = pick64();
    i.flags_in = 4'($urandom());
    i.condition = 4'($urandom());
    i.immediate = pick64();
    i.bit_field = 6'($urandom());
    i.fallback_flags = 4'($urandom());
    i.modifier_kind = 4'($urandom());
    i.shift_amount = 6'($urandom());
    i.instruction_address = pick64();
    return i;
  endfunction

  // called at a falling edge; returns at the falling edge after the transfer
  task automatic send_insn(input insn_t i);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req.valid <= 1'b1;
    req.operation <= i.operation;
    req.operand_a <= i.operand_a;
    req.operand_b <= i.operand_b;
    req.operand_c <= i.operand_c;
    req.flags_in <= i.flags_in;
    req.condition <= i.condition;
    req.immediate <= i.immediate;
    req.bit_field <= i.bit_field;
    req.fallback_flags <= i.fallback_flags;
    req.modifier_kind <= i.modifier_kind;
    req.shift_amount <= i.shift_amount;
    req.instruction_address <= i.instruction_address;
    do @(posedge clk); while (!req.ready);
    sb.note_insn(i);
    @(negedge clk);
  endtask

  // sample results and randomly stall the output
  initial begin
    int stall;
    outcome_t got;
    rsp.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
      if (stall > 0) begin
        rsp.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      rsp.ready <= 1'b1;
      do @(posedge clk); while (!rsp.valid);
      got = '{rsp.dest_value, rsp.dest_valid, rsp.flags_out, rsp.flags_valid,
              rsp.is_branch, rsp.branch_taken, rsp.branch_target, rsp.exception_code};
      sb.check_result(got);
      @(negedge clk);
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles <= 0;
    else if (!stim_done || sb.pending.size() != 0) idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout with %0d results outstanding", sb.pending.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    insn_t i;
    int n;
    idle_cycles = 0;
    stim_done = 0;
    req.valid = 1'b0;
    req.operation = '0; req.operand_a = '0; req.operand_b = '0; req.operand_c = '0;
    req.flags_in = '0; req.condition = '0; req.immediate = '0; req.bit_field = '0;
    req.fallback_flags = '0; req.modifier_kind = '0; req.shift_amount = '0;
    req.instruction_address = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // every opcode with all-ones operands, then each defined opcode with zero operands
    for (n = 0; n < 64; n++) begin
      i = '1;
      i.operation = 6'(n);
      i.modifier_kind = 4'($urandom_range(0, 15));
      send_insn(i);
    end
    for (n = 0; n < 47; n++) begin
      i = '0;
      i.operation = 6'(n);
      send_insn(i);
    end
    // divide by zero, signed overflow on add, 32-bit subtract borrow, rotate, UBFM wraparound, SXTW extend
    i = random_insn(); i.operation = OP_UDIV_X; i.operand_b = 64'd0; send_insn(i);
    i = random_insn(); i.operation = OP_ADDS_X_IMM;
    i.operand_a = 64'h7FFF_FFFF_FFFF_FFFF; i.immediate = 64'd1; send_insn(i);
    i = random_insn(); i.operation = OP_SUBS_W_IMM; i.operand_a = 64'd0;
    i.immediate = 64'd1;
    send_insn(i);
    i = random_insn(); i.operation = OP_ORR_X_SHF; i.modifier_kind = MOD_ROR;
    i.operand_a = 64'd0; i.shift_amount = 6'd63; send_insn(i);
    i = random_insn(); i.operation = OP_UBFM_X; i.bit_field = 6'd3; i.shift_amount = 6'd60;
    send_insn(i);
    i = random_insn(); i.operation = OP_ADD_X_EXT; i.modifier_kind = MOD_SXTW;
    i.shift_amount = 6'd63; send_insn(i);

    for (n = 0; n < NUM_RANDOM; n++) send_insn(random_insn());
    req.valid <= 1'b0;
    stim_done = 1;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 20) @(posedge clk);
    $display("checked %0d results over all 64 operation codes, %0d mismatches",
             sb.checked, sb.errors);
    if (sb.errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end
endmodule
